/* hdl/double_ended_queue_unit_assert.svh */
// Assertion macros for the double-ended queue unit.
// Included by the top level; depends on signals named clk and rst in scope.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deq assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deq assertion failed");
`else
`define DEQ_ASSERT_NOW(label, ante, cons)
`define DEQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hdl/deq_pkg.sv */
// Shared types and codes for the double-ended queue unit.
// No dependencies.
package deq_pkg;

  // Request codes carried on req_type.
  typedef logic [2:0] req_code_t;
  localparam req_code_t REQ_PUSH_FRONT = 3'd0;
  localparam req_code_t REQ_PUSH_REAR  = 3'd1;
  localparam req_code_t REQ_POP_FRONT  = 3'd2;
  localparam req_code_t REQ_POP_REAR   = 3'd3;
  localparam req_code_t REQ_DUMP       = 3'd4;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam int DataWidth = 32;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_POP     = 4'b0010,
    S_DUMP_RD = 4'b0100,
    S_DUMP_WR = 4'b1000
  } state_t;

endpackage

/* hdl/deq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit: ring pointers, controller, output register.
// Depends on deq_pkg, deq_ram and double_ended_queue_unit_assert.svh.
//
// Usage:
// A bounded double-ended queue of signed 32-bit values held in one RAM of DEPTH entries.
// Requests arrive on the input channel (req_type, item_value; in_valid/in_ready) and
// results leave on the output channel (out_value, status, last, item_count, is_empty;
// out_valid/out_ready). Each result carries the item count after the request.
// Push: one transaction in, one result out on the next cycle; a push can be taken
// every cycle while results drain. Pop: the RAM read is registered, then the result
// is loaded in S_POP. Dump: one result per held item (RAM read then output load, the
// read waiting while the output stalls), the last one flagged; on an empty queue a
// single empty result. Full and empty cases answer on the next cycle. Codes 5 to 7 are
// accepted and dropped without a result.
// A new request is taken only when the controller is idle and the output register
// is empty or being drained; a stalled receiver holds the result and blocks input.
// Reset empties the queue at once (front pointer and count cleared); RAM contents
// are not cleared, since only written entries are ever read.
module double_ended_queue_unit #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  deq_pkg::req_code_t   req_type,
  input  logic signed [31:0]   item_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_value,
  output deq_pkg::status_t     status,
  output logic                 last,
  output logic [CW-1:0]        item_count,
  output logic                 is_empty
);

  import deq_pkg::*;

  // Ring pointer increment with wrap at DEPTH.
  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p);
    logic [IW-1:0] r;
    if (p == IW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  state_t state, state_next;
  logic [IW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] dump_ptr, dump_ptr_next;
  logic [CW-1:0] dump_left, dump_left_next;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [DataWidth-1:0] wr_data;
  logic [IW-1:0]        rd_addr;
  logic [DataWidth-1:0] rd_data;

  logic                 in_fire;
  logic                 load;
  logic signed [31:0]   ld_value;
  status_t              ld_status;
  logic                 ld_last;
  logic [CW-1:0]        ld_count;

  logic                 full;
  logic                 empty;
  logic [IW-1:0]        front_dec;
  logic [CW:0]          rear_sum;
  logic [CW:0]          rear_m1;
  logic [IW-1:0]        rear_wr;
  logic [IW-1:0]        rear_rd;

  // Ring storage.
  deq_ram #(
    .WIDTH(DataWidth),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Handshake on the input side.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Occupancy flags and wrapped positions; sums stay below twice DEPTH.
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
  assign rear_sum  = (CW + 1)'(front) + (CW + 1)'(count);
  assign rear_m1   = rear_sum - 1'b1;
  assign rear_wr   = (rear_sum >= (CW + 1)'(DEPTH)) ? IW'(rear_sum - (CW + 1)'(DEPTH))
                                                    : IW'(rear_sum);
  assign rear_rd   = (rear_m1 >= (CW + 1)'(DEPTH)) ? IW'(rear_m1 - (CW + 1)'(DEPTH))
                                                   : IW'(rear_m1);

  // Controller: decodes requests, drives the RAM and loads the output register.
  always_comb begin
    state_next     = state;
    front_next     = front;
    count_next     = count;
    dump_ptr_next  = dump_ptr;
    dump_left_next = dump_left;
    wr_en          = 1'b0;
    wr_addr        = front;
    wr_data        = item_value;
    rd_addr        = front;
    load           = 1'b0;
    ld_value       = '0;
    ld_status      = ST_OK;
    ld_last        = 1'b1;
    ld_count       = count;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
              load = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
                if (req_type == REQ_PUSH_FRONT) begin
                  front_next = front_dec;
                  wr_addr    = front_dec;
                end else begin
                  wr_addr = rear_wr;
                end
              end
              ld_count = count_next;
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
                state_next = S_POP;
                if (req_type == REQ_POP_FRONT) begin
                  rd_addr    = front;
                  front_next = ring_inc(front);
                end else begin
                  rd_addr = rear_rd;
                end
              end
            end
            REQ_DUMP: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                dump_ptr_next  = front;
                dump_left_next = count;
                state_next     = S_DUMP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        // Read data for the popped entry arrives this cycle.
        load       = 1'b1;
        ld_value   = rd_data;
        state_next = S_IDLE;
      end
      S_DUMP_RD: begin
        // Read the current entry; move on to the output load only when the output slot is free at the next edge.
        rd_addr = dump_ptr;
        if (!out_valid || out_ready) begin
          dump_ptr_next  = ring_inc(dump_ptr);
          dump_left_next = dump_left - 1'b1;
          state_next     = S_DUMP_WR;
        end
      end
      S_DUMP_WR: begin
        load       = 1'b1;
        ld_value   = rd_data;
        ld_last    = (dump_left == '0);
        state_next = (dump_left == '0) ? S_IDLE : S_DUMP_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Dump walk registers and result payload.
  always_ff @(posedge clk) begin
    dump_ptr  <= dump_ptr_next;
    dump_left <= dump_left_next;
    if (load) begin
      out_value  <= ld_value;
      status     <= ld_status;
      last       <= ld_last;
      item_count <= ld_count;
      is_empty   <= (ld_count == '0);
    end
  end

  `include "double_ended_queue_unit_assert.svh"

  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `DEQ_ASSERT_NOW(a_empty_status, out_valid && (status == ST_EMPTY), item_count == '0)
  `DEQ_ASSERT_NOW(a_full_status, out_valid && (status == ST_FULL), item_count == CW'(DEPTH))
  `DEQ_ASSERT_NOW(a_no_accept_in_dump, (state == S_DUMP_RD) || (state == S_DUMP_WR), !in_ready)
  `DEQ_ASSERT_NEXT(a_pop_result, state == S_POP, out_valid && (status == ST_OK) && last)

endmodule
